// ----- rtl/core/bfpa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bfpa_pkg
// Operation and status codes shared by the page allocator and its users.
// ----------------------------------------------------------------------------
package bfpa_pkg;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_ALLOC = 2'd1;
    localparam logic [1:0] FUNC_FREE  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOFIT = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/core/best_fit_page_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_page_allocator
// Best-fit free page allocator. Free extents live in one address-ordered
// table; free merges with neighboring extents.
// ----------------------------------------------------------------------------
// A free into a full table first walks the whole table to check that a merge frees a slot.
// One transaction is worked at a time; the extent memory's single read port
// and single write port pace every table walk at one entry per cycle.
// Reset empties the table (extent count zero) and clears the free page count.
// The extent memory itself is not cleared; only entries below the count are read.
module best_fit_page_allocator
    import bfpa_pkg::*;
#(
    parameter int MAX_EXTENTS = 64,
    parameter int PAGE_BITS   = 20
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // request channel
    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire  [1:0]            i_func,
    input  wire  [PAGE_BITS-1:0]  i_page_index,
    input  wire  [PAGE_BITS:0]    i_page_count,
    // response channel
    output logic                  o_valid,
    input  wire                   i_stall,
    output logic [1:0]            o_status,
    output logic [PAGE_BITS-1:0]  o_alloc_start,
    output logic [PAGE_BITS:0]    o_free_total
);

    localparam int PB = PAGE_BITS;
    localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int EW = 2 * PB + 1;   // {start, length}
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EXTENTS);
    localparam logic [PB:0]   SPACE   = {1'b1, {PB{1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_TCHK, S_MRGB, S_MRG, S_INSB, S_INS, S_INS0,
        S_BEST, S_BFIN, S_REM, S_DONE
    } t_state;

    // extent memory, registered read
    logic [EW-1:0] r_mem [MAX_EXTENTS];
    logic [EW-1:0] r_rd;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [EW-1:0] mem_wd;

    t_state         r_state, n_state;
    logic [PB-1:0]  r_bs, n_bs;          // working block start
    logic [PB:0]    r_bl, n_bl;          // working block length / request
    logic [CW-1:0]  r_used, n_used;      // valid extents, packed at low slots
    logic [CW-1:0]  r_i, n_i;            // walk index (data in r_rd)
    logic [CW-1:0]  r_w, n_w;            // compaction write index
    logic           r_touch, n_touch;
    logic           r_found, n_found;
    logic [CW-1:0]  r_best, n_best;
    logic [PB-1:0]  r_bst, n_bst;
    logic [PB:0]    r_blen, n_blen;
    logic [PB:0]    r_free, n_free;
    logic [1:0]     r_status, n_status;
    logic [PB-1:0]  r_astart, n_astart;
    logic           r_ovalid, n_ovalid;
    logic [1:0]     r_ostat, n_ostat;
    logic [PB-1:0]  r_oast, n_oast;
    logic [PB:0]    r_ofree, n_ofree;

    logic [PB-1:0]  rd_start;
    logic [PB:0]    rd_len;
    logic [PB:0]    blk_end, ext_end, room, clip_cnt;
    logic [PB+1:0]  sat_sum;
    logic [PB:0]    sat_free;
    logic           hit_after, hit_before, fit;
    logic [PB:0]    tail_start;

    assign rd_start = r_rd[EW-1 -: PB];
    assign rd_len   = r_rd[PB:0];

    assign blk_end    = {1'b0, r_bs} + r_bl;
    assign ext_end    = {1'b0, rd_start} + rd_len;
    assign hit_after  = (blk_end == {1'b0, rd_start});   // block runs into extent
    assign hit_before = (ext_end == {1'b0, r_bs});       // extent runs into block
    assign fit        = (rd_len >= r_bl) && (!r_found || (rd_len < r_blen));
    assign tail_start = {1'b0, r_bst} + r_bl;

    // clip a new extent so it does not run past the top of the page space
    assign room     = SPACE - {1'b0, i_page_index};
    assign clip_cnt = (i_page_count > room) ? room : i_page_count;

    // saturating free count add; operand is the clipped count or r_bl
    always_comb begin
        sat_sum  = {1'b0, r_free} + ((r_state == S_IDLE) ? {1'b0, clip_cnt} : {1'b0, r_bl});
        sat_free = (sat_sum > {1'b0, SPACE}) ? SPACE : sat_sum[PB:0];
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_bs     = r_bs;
        n_bl     = r_bl;
        n_used   = r_used;
        n_i      = r_i;
        n_w      = r_w;
        n_touch  = r_touch;
        n_found  = r_found;
        n_best   = r_best;
        n_bst    = r_bst;
        n_blen   = r_blen;
        n_free   = r_free;
        n_status = r_status;
        n_astart = r_astart;
        n_ovalid = r_ovalid && i_stall;
        n_ostat  = r_ostat;
        n_oast   = r_oast;
        n_ofree  = r_ofree;
        mem_we   = 1'b0;
        mem_wa   = '0;
        mem_wd   = '0;
        mem_re   = 1'b0;
        mem_ra   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_status = STAT_OK;
                    n_astart = '0;
                    n_bs     = i_page_index;
                    n_bl     = clip_cnt;
                    n_state  = S_DONE;
                    case (i_func)
                        FUNC_ADD: begin
                            if (i_page_count == '0) begin
                                n_state = S_DONE;
                            end else if (r_used == MAX_CNT) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_free  = sat_free;
                                n_w     = r_used;
                                n_state = S_INSB;
                            end
                        end
                        FUNC_FREE: begin
                            if (i_page_count == '0) begin
                                n_state = S_DONE;
                            end else if (r_used == MAX_CNT) begin
                                // full table: a merge must free a slot
                                n_touch = 1'b0;
                                n_i     = '0;
                                mem_re  = 1'b1;
                                mem_ra  = '0;
                                n_state = S_TCHK;
                            end else begin
                                n_state = S_MRGB;
                            end
                        end
                        FUNC_ALLOC: begin
                            n_bl = i_page_count;
                            if (i_page_count == '0 || i_page_count > r_free ||
                                r_used == '0) begin
                                n_status = STAT_NOFIT;
                            end else begin
                                n_found = 1'b0;
                                n_i     = '0;
                                mem_re  = 1'b1;
                                mem_ra  = '0;
                                n_state = S_BEST;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end

            S_TCHK: begin
                if (r_i == r_used - 1'b1) begin
                    if (!(r_touch || hit_after || hit_before)) begin
                        n_status = STAT_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_MRGB;
                    end
                end else begin
                    n_touch = r_touch || hit_after || hit_before;
                    n_i     = r_i + 1'b1;
                    mem_re  = 1'b1;
                    mem_ra  = AW'(r_i + 1'b1);
                end
            end

            S_MRGB: begin
                n_free = sat_free;
                n_w    = '0;
                if (r_used == '0) begin
                    n_state = S_INSB;
                end else begin
                    n_i     = '0;
                    mem_re  = 1'b1;
                    mem_ra  = '0;
                    n_state = S_MRG;
                end
            end

            // compaction walk: merged extents drop out, others slide down
            S_MRG: begin
                if (hit_after) begin
                    n_bl = r_bl + rd_len;
                end else if (hit_before) begin
                    n_bs = rd_start;
                    n_bl = r_bl + rd_len;
                end else begin
                    mem_we = 1'b1;
                    mem_wa = AW'(r_w);
                    mem_wd = r_rd;
                    n_w    = r_w + 1'b1;
                end
                if (r_i == r_used - 1'b1) begin
                    n_state = S_INSB;
                end else begin
                    n_i    = r_i + 1'b1;
                    mem_re = 1'b1;
                    mem_ra = AW'(r_i + 1'b1);
                end
            end

            // sorted insert into the r_w entries, walking down from the top
            S_INSB: begin
                if (r_w == '0) begin
                    mem_we  = 1'b1;
                    mem_wa  = '0;
                    mem_wd  = {r_bs, r_bl};
                    n_used  = CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_i     = r_w - 1'b1;
                    mem_re  = 1'b1;
                    mem_ra  = AW'(r_w - 1'b1);
                    n_state = S_INS;
                end
            end

            S_INS: begin
                mem_we = 1'b1;
                mem_wa = AW'(r_i + 1'b1);
                if (rd_start > r_bs) begin
                    mem_wd = r_rd;
                    if (r_i == '0) begin
                        n_state = S_INS0;
                    end else begin
                        n_i    = r_i - 1'b1;
                        mem_re = 1'b1;
                        mem_ra = AW'(r_i - 1'b1);
                    end
                end else begin
                    mem_wd  = {r_bs, r_bl};
                    n_used  = r_w + 1'b1;
                    n_state = S_DONE;
                end
            end

            S_INS0: begin
                mem_we  = 1'b1;
                mem_wa  = '0;
                mem_wd  = {r_bs, r_bl};
                n_used  = r_w + 1'b1;
                n_state = S_DONE;
            end

            S_BEST: begin
                if (fit) begin
                    n_found = 1'b1;
                    n_best  = r_i;
                    n_bst   = rd_start;
                    n_blen  = rd_len;
                end
                if (r_i == r_used - 1'b1) begin
                    n_state = S_BFIN;
                end else begin
                    n_i    = r_i + 1'b1;
                    mem_re = 1'b1;
                    mem_ra = AW'(r_i + 1'b1);
                end
            end

            S_BFIN: begin
                if (!r_found) begin
                    n_status = STAT_NOFIT;
                    n_state  = S_DONE;
                end else begin
                    n_astart = r_bst;
                    n_free   = r_free - r_bl;
                    if (r_blen > r_bl) begin
                        // keep the tail in place
                        mem_we  = 1'b1;
                        mem_wa  = AW'(r_best);
                        mem_wd  = {tail_start[PB-1:0], r_blen - r_bl};
                        n_state = S_DONE;
                    end else begin
                        n_used = r_used - 1'b1;
                        if (r_best + 1'b1 < r_used) begin
                            n_i     = r_best + 1'b1;
                            mem_re  = 1'b1;
                            mem_ra  = AW'(r_best + 1'b1);
                            n_state = S_REM;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end

            // close the gap; r_used already holds the reduced count
            S_REM: begin
                mem_we = 1'b1;
                mem_wa = AW'(r_i - 1'b1);
                mem_wd = r_rd;
                if (r_i == r_used) begin
                    n_state = S_DONE;
                end else begin
                    n_i    = r_i + 1'b1;
                    mem_re = 1'b1;
                    mem_ra = AW'(r_i + 1'b1);
                end
            end

            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_status;
                    n_oast   = r_astart;
                    n_ofree  = r_free;
                    n_state  = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_free   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_free   <= n_free;
            r_ovalid <= n_ovalid;
        end
        r_bs     <= n_bs;
        r_bl     <= n_bl;
        r_i      <= n_i;
        r_w      <= n_w;
        r_touch  <= n_touch;
        r_found  <= n_found;
        r_best   <= n_best;
        r_bst    <= n_bst;
        r_blen   <= n_blen;
        r_status <= n_status;
        r_astart <= n_astart;
        r_ostat  <= n_ostat;
        r_oast   <= n_oast;
        r_ofree  <= n_ofree;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_ostat;
    assign o_alloc_start = r_oast;
    assign o_free_total  = r_ofree;

endmodule
`default_nettype wire
